// ----- hdl/pidmi_pkg.sv -----
// pidmi_pkg: shared types, constants and helper functions of the pid controller
`default_nettype none

package pidmi_pkg;

  // data format, signed Q16.16
  localparam int DW        = 32;
  localparam int FRAC_BITS = 16;
  localparam int INV_W     = 31;
  localparam int KIND_W    = 2;
  localparam int TRIG_W    = 2;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;

  // sums of two data values, increments and multiplier operand a
  localparam int SUM_W     = DW + 2;
  // 23x - 16p + 5p2 numerator of the third-order increment
  localparam int AB3_W     = DW + 6;
  localparam int AB3_DEN   = 12;
  localparam int DIGIT_W   = 4;
  localparam int DIV_PAD_W = ((AB3_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam int DIV_STEPS = DIV_PAD_W / DIGIT_W;

  // multiplier magnitudes: |a| stays below 2^(DW+1), |g| at most 2^(DW-1)
  localparam int MAG_A_W = DW + 1;
  localparam int PROD_W  = MAG_A_W + DW;

  localparam logic [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {{(SUM_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic [INV_W-1:0] INV_DT_RST = INV_W'(1) << FRAC_BITS;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE,
    KIND_CLEAR,
    KIND_PRELOAD
  } kind_t;

  typedef enum logic [TRIG_W-1:0] {
    TRIG_INTEGRATE,
    TRIG_HOLD,
    TRIG_RESET
  } trig_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE,
    MODE_RECT,
    MODE_TRAP,
    MODE_AB2,
    MODE_AB3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP,
    REG_KI_DT,
    REG_KD,
    REG_INV_DT,
    REG_INT_MODE,
    REG_STD_FORM,
    REG_CLIP_MIN,
    REG_CLIP_MAX
  } reg_idx_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] a;
    logic [DW-1:0]    g;
  } mul_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] res;
    logic          ovf;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [AB3_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [SUM_W-1:0] sext_sum(input logic [DW-1:0] v);
    return {{(SUM_W-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic sum_ovf(input logic signed [SUM_W-1:0] s);
    return (s > SUM_MAX) || (s < SUM_MIN);
  endfunction

  function automatic logic [DW-1:0] sum_sat(input logic signed [SUM_W-1:0] s);
    logic [DW-1:0] r;
    if (s > SUM_MAX) begin
      r = DATA_MAX;
    end else if (s < SUM_MIN) begin
      r = DATA_MIN;
    end else begin
      r = s[DW-1:0];
    end
    return r;
  endfunction

  // halve, rounding toward zero
  function automatic logic signed [SUM_W-1:0] half_tz(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = s + {{(SUM_W-1){1'b0}}, s[SUM_W-1]};
    return {t[SUM_W-1], t[SUM_W-1:1]};
  endfunction

  // one quotient digit of a divide by twelve: returns {digit, remainder}
  function automatic logic [2*DIGIT_W-1:0] div12_nib(input logic [DIGIT_W-1:0] rem,
                                                     input logic [DIGIT_W-1:0] nib);
    logic [DIGIT_W:0]   t;
    logic [DIGIT_W-1:0] r;
    logic [DIGIT_W-1:0] q;
    r = rem;
    q = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {r, nib[i]};
      if (t >= (DIGIT_W+1)'(AB3_DEN)) begin
        r    = DIGIT_W'(t - (DIGIT_W+1)'(AB3_DEN));
        q[i] = 1'b1;
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end
    return {q, r};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/pid_controller_multi_integrator.sv -----
// pid_controller_multi_integrator: sequenced fixed-point pid step with selectable integrator
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//   in       in         in_valid / in_ready     kind, sample, pvdot_valid, pvdot, trigger_mode
//   out      out        out_valid / out_ready   drive_value, was_clipped
//
// a sample item runs from acceptance to its result register through the derivative, the
// increment, the integrator update and the terms, with a final kp scaling in standard form
// and a third-order numerator and divide for that integrator; it uses the two-stage shared
// multiplier three or four times in series and the nibble-serial divide by twelve
// clear, preload and unused kinds are handled on acceptance and give no result
// reset (synchronous, active high) zeroes the controller state and restores register defaults
// the input side is free again while a finished result waits; a stalled result stalls
// only the next sample at its final step
`default_nettype none

module pid_controller_multi_integrator
  import pidmi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]        cfg_data,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    kind,
  input  logic signed [DW-1:0] sample,
  input  logic                 pvdot_valid,
  input  logic signed [DW-1:0] pvdot,
  input  logic [TRIG_W-1:0]    trigger_mode,
  // result items
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] drive_value,
  output logic                 was_clipped
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DERIV,
    S_DERIV_W,
    S_DELTA,
    S_AB3A,
    S_AB3B,
    S_AB3C,
    S_DIV,
    S_DIV_W,
    S_INTEG,
    S_INTEG_W,
    S_TERM1,
    S_TERM1_W,
    S_TERM2,
    S_TERM2_W,
    S_TERM3,
    S_TERM3_W,
    S_CLIP
  } state_t;

  // configuration registers
  logic signed [DW-1:0] kp;
  logic signed [DW-1:0] ki_dt;
  logic signed [DW-1:0] kd;
  logic [INV_W-1:0]     inv_dt;
  logic [MODE_W-1:0]    integrator_mode;
  logic                 standard_form;
  logic signed [DW-1:0] clip_min;
  logic signed [DW-1:0] clip_max;

  // controller state
  logic signed [DW-1:0] prev_input;
  logic signed [DW-1:0] prev2_input;
  logic signed [DW-1:0] integral_sum;

  // sequencer and working registers of the current sample
  state_t                  state;
  logic signed [DW-1:0]    x;
  logic signed [DW-1:0]    pv;
  logic                    pv_sel;
  logic [TRIG_W-1:0]       trig;
  logic signed [DW-1:0]    d;
  logic signed [SUM_W-1:0] delta;
  logic signed [AB3_W-1:0] acc;
  logic signed [DW-1:0]    v;
  logic                    flag;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  logic signed [SUM_W-1:0] x_s;
  logic signed [SUM_W-1:0] p_s;
  logic signed [SUM_W-1:0] i_s;
  logic signed [SUM_W-1:0] v_s;
  logic signed [SUM_W-1:0] mres_s;
  logic signed [SUM_W-1:0] trap_s;
  logic signed [SUM_W-1:0] ab2_s;
  logic signed [SUM_W-1:0] delta_simple;
  logic signed [SUM_W-1:0] int_sum;
  logic signed [SUM_W-1:0] t1_std_sum;
  logic signed [SUM_W-1:0] t1_par_sum;
  logic signed [SUM_W-1:0] t2_sum;
  logic signed [DW-1:0]    ibase;
  logic signed [AB3_W-1:0] xa;
  logic signed [AB3_W-1:0] pa;
  logic signed [AB3_W-1:0] p2a;
  logic signed [DW-1:0]    clip_v;
  logic                    clip_hit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      kp              <= '0;
      ki_dt           <= '0;
      kd              <= '0;
      inv_dt          <= INV_DT_RST;
      integrator_mode <= MODE_NONE;
      standard_form   <= 1'b0;
      clip_min        <= DATA_MIN;
      clip_max        <= DATA_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KP:       kp              <= cfg_data;
        REG_KI_DT:    ki_dt           <= cfg_data;
        REG_KD:       kd              <= cfg_data;
        REG_INV_DT:   inv_dt          <= cfg_data[INV_W-1:0];
        REG_INT_MODE: integrator_mode <= cfg_data[MODE_W-1:0];
        REG_STD_FORM: standard_form   <= cfg_data[0];
        REG_CLIP_MIN: clip_min        <= cfg_data;
        REG_CLIP_MAX: clip_max        <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- shared units
  pidmi_qmul u_qmul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  pidmi_div12 u_div12 (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // ---------------------------------------------------------------- datapath terms
  assign x_s    = sext_sum(x);
  assign p_s    = sext_sum(prev_input);
  assign i_s    = sext_sum(integral_sum);
  assign v_s    = sext_sum(v);
  assign mres_s = sext_sum(mrsp.res);

  // trigger reset drops the old integrator before the (zero) increment is added
  assign ibase   = (trig == TRIG_RESET) ? '0 : integral_sum;
  assign int_sum = sext_sum(ibase) + mres_s;

  assign t1_std_sum = x_s + i_s;
  assign t1_par_sum = mres_s + i_s;
  assign t2_sum     = v_s + mres_s;

  // low-order increments, all formed in one step
  assign trap_s = x_s + p_s;
  assign ab2_s  = (x_s <<< 1) + x_s - p_s;

  always_comb begin
    delta_simple = '0;
    if (trig == TRIG_INTEGRATE) begin
      case (integrator_mode)
        MODE_RECT: delta_simple = x_s;
        MODE_TRAP: delta_simple = half_tz(trap_s);
        MODE_AB2:  delta_simple = half_tz(ab2_s);
        default:   delta_simple = '0;
      endcase
    end
  end

  // third-order numerator operands
  assign xa  = {{(AB3_W-DW){x[DW-1]}}, x};
  assign pa  = {{(AB3_W-DW){prev_input[DW-1]}}, prev_input};
  assign p2a = {{(AB3_W-DW){prev2_input[DW-1]}}, prev2_input};

  // output limits; an inverted window favors clip_max
  always_comb begin
    clip_v   = v;
    clip_hit = 1'b0;
    if (v > clip_max) begin
      clip_v   = clip_max;
      clip_hit = 1'b1;
    end else if (v < clip_min) begin
      clip_v   = clip_min;
      clip_hit = 1'b1;
    end
  end

  // multiplier operand selection per sequencer step
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.g     = '0;
    case (state)
      S_DERIV: begin
        mreq.start = !pv_sel;
        mreq.a     = x_s - p_s;
        mreq.g     = {1'b0, inv_dt};
      end
      S_INTEG: begin
        mreq.start = 1'b1;
        mreq.a     = delta;
        mreq.g     = ki_dt;
      end
      S_TERM1: begin
        mreq.start = !standard_form;
        mreq.a     = x_s;
        mreq.g     = kp;
      end
      S_TERM2: begin
        mreq.start = 1'b1;
        mreq.a     = sext_sum(d);
        mreq.g     = kd;
      end
      S_TERM3: begin
        mreq.start = 1'b1;
        mreq.a     = v_s;
        mreq.g     = kp;
      end
      default: ;
    endcase
  end

  always_comb begin
    dreq.start = (state == S_DIV);
    dreq.num   = acc;
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      flag         <= 1'b0;
      integral_sum <= '0;
      prev_input   <= '0;
      prev2_input  <= '0;
    end else begin
      // in S_CLIP the delivery below takes over the output register
      if (out_valid && out_ready && (state != S_CLIP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (kind)
              KIND_SAMPLE: begin
                x      <= sample;
                pv     <= pvdot;
                pv_sel <= pvdot_valid;
                trig   <= trigger_mode;
                flag   <= 1'b0;
                state  <= S_DERIV;
              end
              KIND_CLEAR: begin
                integral_sum <= '0;
                prev_input   <= '0;
                prev2_input  <= '0;
              end
              KIND_PRELOAD: begin
                integral_sum <= sample;
              end
              default: ;
            endcase
          end
        end
        // derivative: external rate, or (x - prev) * inv_dt
        S_DERIV: begin
          if (pv_sel) begin
            d     <= pv;
            state <= S_DELTA;
          end else begin
            state <= S_DERIV_W;
          end
        end
        S_DERIV_W: begin
          if (mrsp.done) begin
            d     <= mrsp.res;
            flag  <= flag | mrsp.ovf;
            state <= S_DELTA;
          end
        end
        // integration increment
        S_DELTA: begin
          if ((trig == TRIG_INTEGRATE) && (integrator_mode == MODE_AB3)) begin
            state <= S_AB3A;
          end else begin
            delta <= delta_simple;
            state <= S_INTEG;
          end
        end
        S_AB3A: begin
          acc   <= (xa <<< 4) + (xa <<< 3) - xa;
          state <= S_AB3B;
        end
        S_AB3B: begin
          acc   <= acc - (pa <<< 4) + (p2a <<< 2);
          state <= S_AB3C;
        end
        S_AB3C: begin
          acc   <= acc + p2a;
          state <= S_DIV;
        end
        S_DIV: begin
          state <= S_DIV_W;
        end
        S_DIV_W: begin
          if (drsp.done) begin
            delta <= drsp.quot;
            state <= S_INTEG;
          end
        end
        // integrator update
        S_INTEG: begin
          state <= S_INTEG_W;
        end
        S_INTEG_W: begin
          if (mrsp.done) begin
            integral_sum <= sum_sat(int_sum);
            flag         <= flag | mrsp.ovf | sum_ovf(int_sum);
            state        <= S_TERM1;
          end
        end
        // proportional and integral terms
        S_TERM1: begin
          if (standard_form) begin
            v     <= sum_sat(t1_std_sum);
            flag  <= flag | sum_ovf(t1_std_sum);
            state <= S_TERM2;
          end else begin
            state <= S_TERM1_W;
          end
        end
        S_TERM1_W: begin
          if (mrsp.done) begin
            v     <= sum_sat(t1_par_sum);
            flag  <= flag | mrsp.ovf | sum_ovf(t1_par_sum);
            state <= S_TERM2;
          end
        end
        // derivative term
        S_TERM2: begin
          state <= S_TERM2_W;
        end
        S_TERM2_W: begin
          if (mrsp.done) begin
            v     <= sum_sat(t2_sum);
            flag  <= flag | mrsp.ovf | sum_ovf(t2_sum);
            state <= standard_form ? S_TERM3 : S_CLIP;
          end
        end
        // standard form scales the whole sum by kp
        S_TERM3: begin
          state <= S_TERM3_W;
        end
        S_TERM3_W: begin
          if (mrsp.done) begin
            v     <= mrsp.res;
            flag  <= flag | mrsp.ovf;
            state <= S_CLIP;
          end
        end
        // deliver once the output register is free, then shift the sample history
        S_CLIP: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            drive_value <= clip_v;
            was_clipped <= flag | clip_hit;
            prev2_input <= (trig == TRIG_RESET) ? '0 : prev_input;
            prev_input  <= x;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pidmi_qmul.sv -----
// pidmi_qmul: shared two-stage fractional multiplier with truncation and saturation
`default_nettype none

module pidmi_qmul
  import pidmi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int MAGQ_W = PROD_W - FRAC_BITS;
  localparam logic [MAGQ_W-1:0] MAG_NEG_LIM = {{(MAGQ_W-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
  localparam logic [MAGQ_W-1:0] MAG_POS_LIM = {{(MAGQ_W-DW+1){1'b0}}, {(DW-1){1'b1}}};

  logic                v1;
  logic                v2;
  logic                neg1;
  logic                neg2;
  logic [MAG_A_W-1:0]  ma;
  logic [DW-1:0]       mg;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    abs_a;
  logic [DW-1:0]       abs_g;
  logic [MAGQ_W-1:0]   mag;

  assign abs_a = req.a[SUM_W-1] ? SUM_W'(0) - req.a : req.a;
  assign abs_g = req.g[DW-1] ? DW'(0) - req.g : req.g;
  assign mag   = prod[PROD_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= req.start;
      v2 <= v1;
    end
  end

  // stage 1: magnitudes and sign, stage 2: product
  always_ff @(posedge clk) begin
    if (req.start) begin
      ma   <= abs_a[MAG_A_W-1:0];
      mg   <= abs_g;
      neg1 <= req.a[SUM_W-1] ^ req.g[DW-1];
    end
    if (v1) begin
      prod <= PROD_W'(ma) * PROD_W'(mg);
      neg2 <= neg1;
    end
  end

  always_comb begin
    rsp.done = v2;
    rsp.ovf  = 1'b0;
    if (neg2) begin
      if (mag > MAG_NEG_LIM) begin
        rsp.res = DATA_MIN;
        rsp.ovf = 1'b1;
      end else begin
        rsp.res = DW'(0) - mag[DW-1:0];
      end
    end else begin
      if (mag > MAG_POS_LIM) begin
        rsp.res = DATA_MAX;
        rsp.ovf = 1'b1;
      end else begin
        rsp.res = mag[DW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pidmi_div12.sv -----
// pidmi_div12: nibble-serial signed divide by twelve, truncating toward zero
`default_nettype none

module pidmi_div12
  import pidmi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic                   busy;
  logic                   done;
  logic                   neg;
  logic [CNT_W-1:0]       cnt;
  logic [DIV_PAD_W-1:0]   work;
  logic [DIGIT_W-1:0]     rem;
  logic [AB3_W-1:0]       mag;
  logic [2*DIGIT_W-1:0]   step;

  assign mag  = req.num[AB3_W-1] ? AB3_W'(0) - req.num : req.num;
  assign step = div12_nib(rem, work[DIV_PAD_W-1 -: DIGIT_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  // dividend digits leave at the top while quotient digits enter at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= {{(DIV_PAD_W-AB3_W){1'b0}}, mag};
      rem  <= '0;
      neg  <= req.num[AB3_W-1];
      cnt  <= CNT_W'(DIV_STEPS);
    end else if (busy) begin
      work <= {work[DIV_PAD_W-DIGIT_W-1:0], step[2*DIGIT_W-1:DIGIT_W]};
      rem  <= step[DIGIT_W-1:0];
      cnt  <= cnt - CNT_W'(1);
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quot = neg ? SUM_W'(0) - work[SUM_W-1:0] : work[SUM_W-1:0];
  end

endmodule

`default_nettype wire

// ----- hdl/pidmi_chk.sv -----
// pidmi_chk: port-level assertions for the pid controller, bound to the top level
`default_nettype none

module pidmi_chk
  import pidmi_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [KIND_W-1:0]    kind,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [DW-1:0] drive_value,
  input logic                 was_clipped
);

  // a sample occupies the block: input closes and no result appears at once
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (kind == KIND_SAMPLE)) |=> (!in_ready && !$rose(out_valid)))
    else $error("sample item did not occupy the sequencer");

  // clear, preload and unused kinds finish in the accepting cycle
  a_ctl_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (kind != KIND_SAMPLE)) |=> in_ready)
    else $error("control item left the block busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(drive_value) && $stable(was_clipped)))
    else $error("result changed or dropped while stalled");

  // reset leaves no pending result and an open input
  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("reset did not return the block to idle");

endmodule

bind pid_controller_multi_integrator pidmi_chk u_pidmi_chk (.*);

`default_nettype wire

// ----- sim/pid_controller_multi_integrator_tb.sv -----
// pid_controller_multi_integrator_tb: self-checking testbench of the fixed-point pid controller
module pid_controller_multi_integrator_tb
  import pidmi_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // unused codes that the block must still handle
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [TRIG_W-1:0] TRIG_SPARE = 2'd3;

  // Q16.16 helpers
  localparam logic [DW-1:0] Q_ONE  = 32'h0001_0000;
  localparam logic [DW-1:0] Q_HALF = 32'h0000_8000;

  // data range of the block, as 64-bit values
  localparam longint Q_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_LO = -Q_HI - 1;
  localparam logic [127:0] MAG_POS_LIMIT = 128'h7FFF_FFFF;
  localparam logic [127:0] MAG_NEG_LIMIT = 128'h8000_0000;

  // run shape
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int GAP_PCT       = 9;
  localparam int SETTLE_CYCLES = 40;    // longest path: AB3 + difference + standard form
  localparam int STALL_LIMIT   = 5000;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AT_FIRST = 300;
  localparam int HOLD_AT_NEXT  = 1300;
  localparam int SEND_CALM_LO  = 700;
  localparam int SEND_CALM_HI  = 1000;
  localparam int RECV_CALM_LO  = 800;
  localparam int RECV_CALM_HI  = 1100;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DW-1:0]     sample;
    logic              pvdot_valid;
    logic [DW-1:0]     pvdot;
    logic [TRIG_W-1:0] trig;
  } pid_item_t;

  typedef struct packed {
    logic [DW-1:0] drive;
    logic          clipped;
  } drive_res_t;

  // block inputs, all known from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DW-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    kind = '0;
  logic signed [DW-1:0] sample = '0;
  logic                 pvdot_valid = 1'b0;
  logic signed [DW-1:0] pvdot = '0;
  logic [TRIG_W-1:0]    trigger_mode = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] drive_value;
  logic                 was_clipped;

  // controller model: registers and state after reset
  longint      gain_kp     = 0;
  longint      gain_ki_dt  = 0;
  longint      gain_kd     = 0;
  longint      rate_inv_dt = 65536;
  logic [2:0]  int_mode    = MODE_NONE;
  logic        std_form    = 1'b0;
  longint      lim_lo      = Q_LO;
  longint      lim_hi      = Q_HI;
  longint      ctl_prev    = 0;
  longint      ctl_prev2   = 0;
  longint      ctl_integ   = 0;
  bit          sat_hit;

  // items waiting for the driver and results waiting for the block
  pid_item_t   item_backlog[$];
  drive_res_t  drive_expect[$];
  int          items_pushed = 0;
  int          items_taken  = 0;
  int          results_seen = 0;
  int          fault_count  = 0;
  int          hold_left    = 0;
  int          idle_cycles  = 0;
  pid_item_t   taken_item;
  pid_item_t   next_item;
  drive_res_t  want;

  pid_controller_multi_integrator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .sample       (sample),
    .pvdot_valid  (pvdot_valid),
    .pvdot        (pvdot),
    .trigger_mode (trigger_mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_value  (drive_value),
    .was_clipped  (was_clipped)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // saturate to the data range, noting that it happened
  function automatic longint sat_data(input longint v);
    if (v > Q_HI) begin
      sat_hit = 1'b1;
      return Q_HI;
    end
    if (v < Q_LO) begin
      sat_hit = 1'b1;
      return Q_LO;
    end
    return v;
  endfunction

  // fixed-point product: exact, magnitude truncated by the fraction bits, then saturated
  function automatic longint fx_mul(input longint a, input longint g);
    logic [127:0] ma;
    logic [127:0] mg;
    logic [127:0] mag;
    logic         neg;
    neg = (a < 0) != (g < 0);
    ma  = (a < 0) ? 128'(-a) : 128'(a);
    mg  = (g < 0) ? 128'(-g) : 128'(g);
    mag = (ma * mg) >> FRAC_BITS;
    if (neg) begin
      if (mag > MAG_NEG_LIMIT) begin
        sat_hit = 1'b1;
        return Q_LO;
      end
      return -longint'(mag[63:0]);
    end
    if (mag > MAG_POS_LIMIT) begin
      sat_hit = 1'b1;
      return Q_HI;
    end
    return longint'(mag[63:0]);
  endfunction

  // register write as the block sees it
  function automatic void reg_apply(input reg_idx_t idx, input logic [DW-1:0] data);
    case (idx)
      REG_KP:       gain_kp     = longint'($signed(data));
      REG_KI_DT:    gain_ki_dt  = longint'($signed(data));
      REG_KD:       gain_kd     = longint'($signed(data));
      REG_INV_DT:   rate_inv_dt = longint'({1'b0, data[INV_W-1:0]});
      REG_INT_MODE: int_mode    = data[MODE_W-1:0];
      REG_STD_FORM: std_form    = data[0];
      REG_CLIP_MIN: lim_lo      = longint'($signed(data));
      REG_CLIP_MAX: lim_hi      = longint'($signed(data));
      default: ;
    endcase
  endfunction

  // one pid step; sample items queue their drive value and clip flag
  function automatic void pid_step_predict(input pid_item_t it);
    longint     x;
    longint     d;
    longint     delta;
    longint     v;
    longint     p1;
    longint     p2;
    drive_res_t r;
    sat_hit = 1'b0;
    delta   = 0;
    p1      = ctl_prev;
    p2      = ctl_prev2;
    case (it.kind)
      KIND_CLEAR: begin
        ctl_prev  = 0;
        ctl_prev2 = 0;
        ctl_integ = 0;
      end
      KIND_PRELOAD: ctl_integ = longint'($signed(it.sample));
      KIND_SAMPLE: begin
        x = longint'($signed(it.sample));
        if (it.pvdot_valid) begin
          d = longint'($signed(it.pvdot));
        end else begin
          d = fx_mul(x - p1, rate_inv_dt);
        end
        // increment only when integrating; hold and the spare code add nothing
        if (it.trig == TRIG_INTEGRATE) begin
          case (int_mode)
            MODE_RECT: delta = x;
            MODE_TRAP: delta = (x + p1) / 2;
            MODE_AB2:  delta = (3 * x - p1) / 2;
            MODE_AB3:  delta = (23 * x - 16 * p1 + 5 * p2) / 12;
            default:   delta = 0;
          endcase
        end
        if (it.trig == TRIG_RESET) begin
          ctl_integ = 0;
        end
        ctl_integ = sat_data(ctl_integ + fx_mul(delta, gain_ki_dt));
        if (std_form) begin
          v = sat_data(x + ctl_integ);
          v = sat_data(v + fx_mul(d, gain_kd));
          v = fx_mul(v, gain_kp);
        end else begin
          v = sat_data(fx_mul(x, gain_kp) + ctl_integ);
          v = sat_data(v + fx_mul(d, gain_kd));
        end
        ctl_prev2 = (it.trig == TRIG_RESET) ? 0 : p1;
        ctl_prev  = x;
        // upper limit wins when the limits are inverted
        if (v > lim_hi) begin
          v = lim_hi;
          sat_hit = 1'b1;
        end else if (v < lim_lo) begin
          v = lim_lo;
          sat_hit = 1'b1;
        end
        r.drive   = v[DW-1:0];
        r.clipped = sat_hit;
        drive_expect.push_back(r);
      end
      default: ;  // spare kind is ignored
    endcase
  endfunction

  function automatic void stage(input pid_item_t it);
    item_backlog.push_back(it);
    items_pushed++;
  endfunction

  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("error: %s", what);
    end
  endfunction

  // mostly small values so the loop stays out of saturation, some full-range and extremes
  function automatic logic [DW-1:0] rand_q();
    logic [DW-1:0] v;
    case ($urandom_range(9))
      0: v = $urandom;
      1: v = $urandom_range(1) ? DATA_MAX : DATA_MIN;
      default: begin
        v = $urandom_range(0, 32'h0010_0000);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [DW-1:0] rand_gain();
    logic [DW-1:0] g;
    case ($urandom_range(9))
      0: g = '0;
      1: g = DATA_MAX;
      2: g = DATA_MIN;
      3, 4: g = $urandom;
      default: begin
        g = $urandom_range(0, 32'h0008_0000);
        if ($urandom_range(1)) g = -g;
      end
    endcase
    return g;
  endfunction

  function automatic pid_item_t rand_item();
    pid_item_t it;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 86)      it.kind = KIND_SAMPLE;
    else if (pick < 91) it.kind = KIND_PRELOAD;
    else if (pick < 96) it.kind = KIND_CLEAR;
    else                it.kind = KIND_SPARE;
    it.sample      = rand_q();
    it.pvdot_valid = $urandom_range(1);
    it.pvdot       = rand_q();
    pick = $urandom_range(99);
    if (pick < 80)      it.trig = TRIG_INTEGRATE;
    else if (pick < 88) it.trig = TRIG_HOLD;
    else if (pick < 96) it.trig = TRIG_RESET;
    else                it.trig = TRIG_SPARE;
    return it;
  endfunction

  function automatic pid_item_t mk_item(input logic [KIND_W-1:0] k, input logic [DW-1:0] s,
                                        input logic pv, input logic [DW-1:0] pd,
                                        input logic [TRIG_W-1:0] t);
    pid_item_t it;
    it.kind        = k;
    it.sample      = s;
    it.pvdot_valid = pv;
    it.pvdot       = pd;
    it.trig        = t;
    return it;
  endfunction

  // one register write over the config channel, model updated on acceptance
  task automatic reg_write(input reg_idx_t idx, input logic [DW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_apply(idx, data);
  endtask

  task automatic load_regs(input logic [DW-1:0] kp_w, input logic [DW-1:0] ki_w,
                           input logic [DW-1:0] kd_w, input logic [DW-1:0] inv_w,
                           input logic [DW-1:0] mode_w, input logic [DW-1:0] form_w,
                           input logic [DW-1:0] lo_w, input logic [DW-1:0] hi_w);
    reg_write(REG_KP,       kp_w);
    reg_write(REG_KI_DT,    ki_w);
    reg_write(REG_KD,       kd_w);
    reg_write(REG_INV_DT,   inv_w);
    reg_write(REG_INT_MODE, mode_w);
    reg_write(REG_STD_FORM, form_w);
    reg_write(REG_CLIP_MIN, lo_w);
    reg_write(REG_CLIP_MAX, hi_w);
  endtask

  // sender pause: everything taken, every result back, then let clear/preload items finish
  task automatic wait_quiet();
    while (items_taken != items_pushed) @(posedge clk);
    while (drive_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender idles at random except in a calm window
  function automatic bit sender_gap();
    if (items_taken >= SEND_CALM_LO && items_taken < SEND_CALM_HI) return 1'b0;
    return $urandom_range(99) < GAP_PCT;
  endfunction

  function automatic bit receiver_gap();
    if (results_seen >= RECV_CALM_LO && results_seen < RECV_CALM_HI) return 1'b0;
    return $urandom_range(99) < GAP_PCT;
  endfunction

  // driver: predict on acceptance, then offer the next item unless idling
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken_item.kind        = kind;
        taken_item.sample      = sample;
        taken_item.pvdot_valid = pvdot_valid;
        taken_item.pvdot       = pvdot;
        taken_item.trig        = trigger_mode;
        pid_step_predict(taken_item);
        items_taken++;
      end
      // payload may only change once the offered item is gone
      if (!in_valid || in_ready) begin
        if (item_backlog.size() != 0 && !sender_gap()) begin
          next_item = item_backlog.pop_front();
          kind         <= next_item.kind;
          sample       <= next_item.sample;
          pvdot_valid  <= next_item.pvdot_valid;
          pvdot        <= next_item.pvdot;
          trigger_mode <= next_item.trig;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest prediction; two long hold-offs fill the block
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_NEXT) begin
          hold_left = LONG_HOLD;
        end
        if (drive_expect.size() == 0) begin
          note_fault($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = drive_expect.pop_front();
          if (drive_value !== want.drive || was_clipped !== want.clipped) begin
            note_fault($sformatf("result %0d drive_value exp %0d got %0d, was_clipped exp %0b got %0b",
                                 results_seen, $signed(want.drive), drive_value,
                                 want.clipped, was_clipped));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !receiver_gap();
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("pid_controller_multi_integrator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus: directed items, two extreme settings, then random phases
  initial begin
    pid_item_t     it;
    int            counted;
    logic [DW-1:0] mode_w;
    logic [DW-1:0] lo_w;
    logic [DW-1:0] hi_w;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // unit kp, half ki_dt, quarter kd, AB3 so the two-deep history matters, limits at +-100.0
    load_regs(Q_ONE, Q_HALF, 32'h0000_4000, Q_ONE, DW'(MODE_AB3), '0,
              -(32'd100 << 16), 32'd100 << 16);
    stage(mk_item(KIND_SAMPLE,  Q_ONE,         1'b0, '0,       TRIG_INTEGRATE));
    stage(mk_item(KIND_SAMPLE,  2 * Q_ONE,     1'b0, '0,       TRIG_INTEGRATE));
    stage(mk_item(KIND_SAMPLE,  32'h0003_8000, 1'b0, '0,       TRIG_INTEGRATE));
    stage(mk_item(KIND_SAMPLE,  DATA_MAX,      1'b0, '0,       TRIG_INTEGRATE));
    stage(mk_item(KIND_SAMPLE,  DATA_MIN,      1'b0, '0,       TRIG_INTEGRATE));
    stage(mk_item(KIND_SAMPLE,  '0,            1'b0, '0,       TRIG_INTEGRATE));
    stage(mk_item(KIND_SAMPLE,  '1,            1'b0, '0,       TRIG_INTEGRATE));
    // external derivative at both extremes
    stage(mk_item(KIND_SAMPLE,  Q_ONE,         1'b1, DATA_MAX, TRIG_INTEGRATE));
    stage(mk_item(KIND_SAMPLE,  Q_ONE,         1'b1, DATA_MIN, TRIG_INTEGRATE));
    // hold, integrator reset, spare trigger code behaving as hold
    stage(mk_item(KIND_SAMPLE,  3 * Q_ONE,     1'b0, '0,       TRIG_HOLD));
    stage(mk_item(KIND_SAMPLE,  3 * Q_ONE,     1'b0, '0,       TRIG_RESET));
    stage(mk_item(KIND_SAMPLE,  -Q_ONE,        1'b0, '0,       TRIG_SPARE));
    stage(mk_item(KIND_SAMPLE,  Q_HALF,        1'b0, '0,       TRIG_INTEGRATE));
    // preload at both extremes, clear, spare kind
    stage(mk_item(KIND_PRELOAD, DATA_MAX,      1'b0, '0,       TRIG_INTEGRATE));
    stage(mk_item(KIND_SAMPLE,  Q_HALF,        1'b0, '0,       TRIG_INTEGRATE));
    stage(mk_item(KIND_PRELOAD, DATA_MIN,      1'b1, '1,       TRIG_SPARE));
    stage(mk_item(KIND_SAMPLE,  Q_HALF,        1'b0, '0,       TRIG_INTEGRATE));
    stage(mk_item(KIND_CLEAR,   '1,            1'b1, '1,       TRIG_RESET));
    stage(mk_item(KIND_SAMPLE,  2 * Q_ONE,     1'b0, '0,       TRIG_INTEGRATE));
    stage(mk_item(KIND_SPARE,   '1,            1'b1, '1,       TRIG_SPARE));
    stage(mk_item(KIND_SAMPLE,  -2 * Q_ONE,    1'b0, '0,       TRIG_INTEGRATE));
    wait_quiet();

    for (int p = 0; p < RAND_PHASES + 2; p++) begin
      if (p == 0) begin
        // top gains, all-ones rate, spare mode and standard form, inverted extreme limits
        load_regs(DATA_MAX, DATA_MAX, DATA_MAX, '1, '1, '1, DATA_MAX, DATA_MIN);
      end else if (p == 1) begin
        // most negative gains, zero rate, no integrator, full output range
        load_regs(DATA_MIN, DATA_MIN, DATA_MIN, '0, '0, '0, DATA_MIN, DATA_MAX);
      end else begin
        // each random phase takes its own integrator mode, spare ones included
        mode_w      = $urandom;
        mode_w[2:0] = 3'(p - 2);
        case ($urandom_range(3))
          0: begin
            lo_w = DATA_MIN;
            hi_w = DATA_MAX;
          end
          1: begin
            lo_w = -$urandom_range(0, 32'h0040_0000);
            hi_w = $urandom_range(0, 32'h0040_0000);
          end
          2: begin
            lo_w = $urandom_range(0, 32'h0010_0000);
            hi_w = -$urandom_range(0, 32'h0010_0000);
          end
          default: begin
            lo_w = $urandom;
            hi_w = $urandom;
          end
        endcase
        load_regs(rand_gain(), rand_gain(), rand_gain(),
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 32'h0004_0000),
                  mode_w, $urandom, lo_w, hi_w);
      end
      // spare kinds are ignored by the block and do not count
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = rand_item();
        stage(it);
        if (it.kind != KIND_SPARE) counted++;
      end
      wait_quiet();
    end

    if (fault_count == 0) begin
      $display("pid_controller_multi_integrator verification clean");
    end else begin
      $display("pid_controller_multi_integrator verification failed");
    end
    $finish;
  end

endmodule
